>>> sv/rhsv_pkg.sv
// Shared types, constants and helper functions for the RGB/HSV pixel adjuster.
`default_nettype none
package rhsv_pkg;

  localparam int HUE_FULL   = 23040;
  localparam int HUE_SECTOR = 3840;
  localparam int Q_ONE      = 4096;
  localparam int DIV_STEPS  = 13;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  // reciprocal of 15 for 16-bit operands: y/15 = (y*RECIP15) >> 19
  localparam logic [16:0] RECIP15 = 17'd34953;

  localparam logic [1:0] REG_HUE = 2'd0;
  localparam logic [1:0] REG_SAT = 2'd1;
  localparam logic [1:0] REG_VAL = 2'd2;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic signed [15:0] hue_off;
    logic signed [13:0] sat_off;
    logic signed [13:0] val_off;
  } cfg_t;

  // classified item as it waits in the queue
  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] d;
    logic [7:0] a;
    sel_t       sel;
    logic       neg;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one step of the two-lane restoring divider
  typedef struct packed {
    logic [7:0]  rem_s;
    logic [12:0] lo_s;
    logic [7:0]  rem_h;
    logic [12:0] lo_h;
    logic [7:0]  dh;
    logic [7:0]  mx;
    sel_t        sel;
    logic        neg;
  } div_t;

  typedef struct packed {
    logic [14:0] h;
    logic [12:0] s;
    logic [12:0] v;
  } hsv_t;

  function automatic div_t div_step(div_t a);
    div_t        n;
    logic [8:0]  rs;
    logic [8:0]  rh;
    logic        qs;
    logic        qh;
    n  = a;
    rs = {a.rem_s, a.lo_s[12]};
    rh = {a.rem_h, a.lo_h[12]};
    qs = (rs >= {1'b0, a.mx});
    qh = (rh >= {1'b0, a.dh});
    n.rem_s = qs ? 8'(rs - {1'b0, a.mx}) : rs[7:0];
    n.rem_h = qh ? 8'(rh - {1'b0, a.dh}) : rh[7:0];
    n.lo_s  = {a.lo_s[11:0], qs};
    n.lo_h  = {a.lo_h[11:0], qh};
    return n;
  endfunction

  // Q12 in 0..4096 to a byte: q*255/4096
  function automatic logic [7:0] to_byte(logic [12:0] q);
    logic [20:0] p;
    p = {q, 8'b0} - 21'(q);
    return p[19:12];
  endfunction

endpackage
`default_nettype wire

>>> sv/rhsv_front.sv
// Front end: finds max, min and hue sector of an incoming pixel.
`default_nettype none
module rhsv_front (
  input  var rhsv_pkg::pix_in_t pix,
  output var rhsv_pkg::entry_t  ent
);
  import rhsv_pkg::*;

  logic [7:0] r, g, b, mx, mn;
  logic [8:0] num;

  assign r = pix.red_in;
  assign g = pix.green_in;
  assign b = pix.blue_in;

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
  end

  always_comb begin
    ent.mx = mx;
    ent.d  = mx - mn;
    if (r == mx) begin
      ent.sel = SEL_RED;
      num     = {1'b0, g} - {1'b0, b};
    end else if (g == mx) begin
      ent.sel = SEL_GREEN;
      num     = {1'b0, b} - {1'b0, r};
    end else begin
      ent.sel = SEL_BLUE;
      num     = {1'b0, r} - {1'b0, g};
    end
    ent.neg = num[8];
    ent.a   = num[8] ? 8'(-num) : num[7:0];
  end

endmodule
`default_nettype wire

>>> sv/rhsv_fifo.sv
// Short queue between the classifying front end and the arithmetic back end.
`default_nettype none
module rhsv_fifo (
  input  var logic             clk,
  input  var logic             rst_n,
  input  var logic             push,
  input  var rhsv_pkg::entry_t wdata,
  input  var logic             pop,
  output var rhsv_pkg::entry_t rdata,
  output var rhsv_pkg::q_stat_t stat
);
  import rhsv_pkg::*;

  entry_t            mem [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

>>> sv/rhsv_back.sv
// Back end: divider pipeline, HSV adjust and conversion back to RGB.
`default_nettype none
module rhsv_back (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var rhsv_pkg::cfg_t    cfg,
  input  var rhsv_pkg::q_stat_t qstat,
  input  var rhsv_pkg::entry_t  ent,
  output var logic              pop,
  output var logic              out_valid,
  input  var logic              out_stall,
  output var rhsv_pkg::pix_out_t out_data
);
  import rhsv_pkg::*;

  logic        en;
  div_t        div_r [DIV_STEPS+1];
  logic        dv_r  [DIV_STEPS+1];
  div_t        dinit;
  logic [20:0] nh, ns;

  hsv_t        hsv_r, hsv_nxt;
  logic        hv_r;
  logic [12:0] c2_r, v2_r, c3_r, m3_r, c4_r, m4_r, x4_r;
  logic [2:0]  sec2_r, sec3_r, sec4_r;
  logic [11:0] k2_r;
  logic [23:0] p3_r;
  logic        cv_r, pv_r, xv_r, ov_r;
  pix_out_t    out_r, out_nxt;

  // the whole pipe moves together whenever the output slot can take an item
  assign en        = !ov_r || !out_stall;
  assign pop       = en && !qstat.empty;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_comb begin
    ns = 21'(ent.d) << 12;
    nh = (21'(ent.a) << 12) - (21'(ent.a) << 8);
    dinit.rem_s = ns[20:13];
    dinit.lo_s  = ns[12:0];
    dinit.rem_h = nh[20:13];
    dinit.lo_h  = nh[12:0];
    dinit.dh    = ent.d;
    dinit.mx    = ent.mx;
    dinit.sel   = ent.sel;
    dinit.neg   = ent.neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= dinit;
      for (int i = 0; i < DIV_STEPS; i++) begin
        div_r[i+1] <= div_step(div_r[i]);
      end
    end
  end

  // adjust stage: hue, saturation and value plus offsets
  always_comb begin
    div_t               dq;
    logic [14:0]        hraw;
    logic [14:0]        q;
    logic signed [17:0] hs;
    logic [12:0]        sraw;
    logic signed [15:0] ss;
    logic [11:0]        w;
    logic [12:0]        vraw;
    logic signed [15:0] vs;
    dq   = div_r[DIV_STEPS];
    q    = {3'b000, dq.lo_h[11:0]};
    hraw = '0;
    if (dq.dh != '0) begin
      case (dq.sel)
        SEL_RED:   hraw = dq.neg ? ((q == '0) ? '0 : 15'(HUE_FULL) - q) : q;
        SEL_GREEN: hraw = dq.neg ? 15'(2*HUE_SECTOR) - q : 15'(2*HUE_SECTOR) + q;
        SEL_BLUE:  hraw = dq.neg ? 15'(4*HUE_SECTOR) - q : 15'(4*HUE_SECTOR) + q;
        default:   hraw = '0;
      endcase
    end
    hs = $signed({3'b000, hraw}) + 18'($signed(cfg.hue_off));
    if (hs < 0) begin
      if (hs + 18'sd23040 >= 0) hsv_nxt.h = 15'(hs + 18'sd23040);
      else hsv_nxt.h = 15'(hs + 18'sd46080);
    end else if (hs < 18'sd23040) begin
      hsv_nxt.h = 15'(hs);
    end else if (hs < 18'sd46080) begin
      hsv_nxt.h = 15'(hs - 18'sd23040);
    end else begin
      hsv_nxt.h = 15'(hs - 18'sd46080);
    end

    sraw = (dq.mx == '0) ? '0 : dq.lo_s;
    ss   = $signed({3'b000, sraw}) + 16'($signed(cfg.sat_off));
    if (ss < 0) hsv_nxt.s = '0;
    else if (ss > 16'sd4096) hsv_nxt.s = 13'(Q_ONE);
    else hsv_nxt.s = 13'(ss);

    // mx*4096/255 = 16*mx + (16*mx)/255
    w    = {dq.mx, 4'b0000};
    vraw = {1'b0, w} + 13'((13'(w) + 13'(w[11:8]) + 13'd1) >> 8);
    vs   = $signed({3'b000, vraw}) + 16'($signed(cfg.val_off));
    if (vs < 0) hsv_nxt.v = '0;
    else if (vs > 16'sd4096) hsv_nxt.v = 13'(Q_ONE);
    else hsv_nxt.v = 13'(vs);
  end

  always_ff @(posedge clk) begin
    logic [25:0] cp;
    logic [14:0] f;
    logic [2:0]  sec;
    if (en) begin
      hsv_r <= hsv_nxt;

      // chroma, sector and ramp weight
      cp = 26'(hsv_r.v) * 26'(hsv_r.s);
      if (hsv_r.h >= 15'(5*HUE_SECTOR)) begin
        sec = 3'd5; f = hsv_r.h - 15'(5*HUE_SECTOR);
      end else if (hsv_r.h >= 15'(4*HUE_SECTOR)) begin
        sec = 3'd4; f = hsv_r.h - 15'(4*HUE_SECTOR);
      end else if (hsv_r.h >= 15'(3*HUE_SECTOR)) begin
        sec = 3'd3; f = hsv_r.h - 15'(3*HUE_SECTOR);
      end else if (hsv_r.h >= 15'(2*HUE_SECTOR)) begin
        sec = 3'd2; f = hsv_r.h - 15'(2*HUE_SECTOR);
      end else if (hsv_r.h >= 15'(HUE_SECTOR)) begin
        sec = 3'd1; f = hsv_r.h - 15'(HUE_SECTOR);
      end else begin
        sec = 3'd0; f = hsv_r.h;
      end
      c2_r   <= cp[24:12];
      v2_r   <= hsv_r.v;
      sec2_r <= sec;
      k2_r   <= sec[0] ? 12'(15'(HUE_SECTOR) - f) : f[11:0];

      p3_r   <= 24'(25'(c2_r) * 25'(k2_r));
      c3_r   <= c2_r;
      m3_r   <= v2_r - c2_r;
      sec3_r <= sec2_r;

      x4_r   <= 13'((33'(p3_r[23:8]) * 33'(RECIP15)) >> 19);
      c4_r   <= c3_r;
      m4_r   <= m3_r;
      sec4_r <= sec3_r;

      out_r  <= out_nxt;
    end
  end

  always_comb begin
    logic [12:0] cr, cg, cb;
    case (sec4_r)
      3'd0:    begin cr = c4_r; cg = x4_r; cb = '0;   end
      3'd1:    begin cr = x4_r; cg = c4_r; cb = '0;   end
      3'd2:    begin cr = '0;   cg = c4_r; cb = x4_r; end
      3'd3:    begin cr = '0;   cg = x4_r; cb = c4_r; end
      3'd4:    begin cr = x4_r; cg = '0;   cb = c4_r; end
      default: begin cr = c4_r; cg = '0;   cb = x4_r; end
    endcase
    out_nxt.red_out   = to_byte(cr + m4_r);
    out_nxt.green_out = to_byte(cg + m4_r);
    out_nxt.blue_out  = to_byte(cb + m4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) dv_r[i] <= 1'b0;
      hv_r <= 1'b0;
      cv_r <= 1'b0;
      pv_r <= 1'b0;
      xv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      dv_r[0] <= pop;
      for (int i = 0; i < DIV_STEPS; i++) dv_r[i+1] <= dv_r[i];
      hv_r <= dv_r[DIV_STEPS];
      cv_r <= hv_r;
      pv_r <= cv_r;
      xv_r <= pv_r;
      ov_r <= xv_r;
    end
  end

endmodule
`default_nettype wire

>>> sv/rgb_hsv_adjust_pixel.sv
// Top level of the RGB/HSV pixel adjuster: config registers, queue and pipes.
//
//   port group | dir | handshake         | payload
//   in_        | in  | in_valid/in_stall | pix_in_t  red, green, blue
//   out_       | out | out_valid/out_stall | pix_out_t red, green, blue
//   cfg_       | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per clock sustained while out_ is not stalled. After acceptance
// an item passes a queue slot, the 13-step divider for saturation and hue,
// and 5 stages to out_valid. Reset clears the queue pointers, valid bits and
// offset registers. A stall on out_ while out_valid is high freezes the whole
// back pipe; the 4-entry queue absorbs input until full, then in_stall rises.
`default_nettype none
module rgb_hsv_adjust_pixel (
  input  var logic               clk,
  input  var logic               rst_n,
  input  var logic               in_valid,
  output var logic               in_stall,
  input  var rhsv_pkg::pix_in_t  in_data,
  output var logic               out_valid,
  input  var logic               out_stall,
  output var rhsv_pkg::pix_out_t out_data,
  input  var logic               cfg_valid,
  output var logic               cfg_ready,
  input  var logic [1:0]         cfg_index,
  input  var logic [15:0]        cfg_data
);
  import rhsv_pkg::*;

  cfg_t    cfg_r;
  entry_t  ent_in, ent_out;
  q_stat_t qstat;
  logic    push, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign push      = in_valid && !qstat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HUE: cfg_r.hue_off <= cfg_data;
        REG_SAT: cfg_r.sat_off <= cfg_data[13:0];
        REG_VAL: cfg_r.val_off <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  rhsv_front u_front (
    .pix (in_data),
    .ent (ent_in)
  );

  rhsv_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (ent_in),
    .pop   (pop),
    .rdata (ent_out),
    .stat  (qstat)
  );

  rhsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .qstat     (qstat),
    .ent       (ent_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

  a_full_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("queue filled without an accepted item");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire
